[rtl/drr_pkg.sv]
// Package for the deficit round robin scheduler: widths, codes, payload structs.
// No dependencies.
package drr_pkg;
  localparam int NumClasses  = 4;
  localparam int QueueDepth  = 64;
  localparam int ClsW        = 2;
  localparam int PtrW        = 6;
  localparam int CntW        = 7;
  localparam int LenW        = 14;
  localparam int TagW        = 16;
  localparam int DefW        = 18;
  localparam int QntW        = 16;
  localparam int AddrW       = ClsW + PtrW;
  localparam int BacklogW    = 9;
  localparam int CfgIdxW     = 3;
  localparam logic [QntW-1:0] QuantumReset = 16'd5000;
  localparam logic [CfgIdxW-1:0] CfgMaskIdx = 3'd4;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_NO_CLASS  = 3'd1,
    ST_FULL      = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ENQ, S_READ, S_WAIT, S_CHECK, S_DONE
  } state_t;

  typedef struct packed {
    logic            opcode;
    logic [ClsW-1:0] class_index;
    logic [LenW-1:0] packet_length;
    logic [TagW-1:0] packet_tag;
  } in_req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [ClsW-1:0]     served_class;
    logic [LenW-1:0]     served_length;
    logic [TagW-1:0]     served_tag;
    logic [BacklogW-1:0] total_backlog;
  } out_req_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] raddr;
  } mem_ctl_t;
endpackage

[rtl/deficit_round_robin_scheduler.sv]
// Top level of the deficit round robin scheduler: sequencer, class state, shared
// deficit unit. Depends on drr_pkg and drr_desc_mem.
//
// One request at a time. An enqueue runs S_ENQ, S_DONE. A dequeue runs S_READ,
// S_WAIT, S_CHECK, S_DONE when the head class fits its deficit, and repeats
// S_READ, S_WAIT, S_CHECK for every rotation through a class that does not fit
// (one descriptor memory read and one compare-and-add in the shared deficit unit
// per visit). Empty dequeues go from S_READ to S_DONE. The result sits in an
// output register; in_stall is high from accept until the result is taken.
module deficit_round_robin_scheduler
  import drr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_req_t             out_data,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [QntW-1:0]      cfg_data
);
  state_t state_r, state_nxt;
  logic [QntW-1:0] quantum_r [NumClasses];
  logic [NumClasses-1:0] mask_r;
  logic [PtrW-1:0] head_r [NumClasses];
  logic [CntW-1:0] count_r [NumClasses];
  logic [DefW-1:0] deficit_r [NumClasses];
  logic [ClsW-1:0] order_r [NumClasses];
  logic [ClsW-1:0] ahead_r;
  logic [ClsW:0]   acount_r;
  logic [BacklogW-1:0] backlog_r;
  in_req_t req_r;
  out_req_t out_r;
  logic out_valid_r;

  mem_ctl_t mctl;
  logic [LenW+TagW-1:0] rdata;
  logic [ClsW-1:0] cur;
  logic [QntW-1:0] qcur;
  logic [DefW-1:0] qeff;
  logic [LenW-1:0] plen;
  logic fits;
  logic [DefW-1:0] dsum;
  status_t enq_st;

  assign cur  = order_r[ahead_r];
  assign qcur = quantum_r[req_r.opcode ? cur : req_r.class_index];
  assign qeff = (qcur == '0) ? DefW'(1) : DefW'(qcur);
  assign plen = rdata[LenW+TagW-1:TagW];
  // Shared unit: one compare and one add/subtract on the current deficit.
  assign fits = DefW'(plen) <= deficit_r[cur];
  assign dsum = fits ? deficit_r[cur] - DefW'(plen) : deficit_r[cur] + qeff;

  // Enqueue outcome: absent class first, then a full queue.
  always_comb begin
    if (!mask_r[req_r.class_index]) begin
      enq_st = ST_NO_CLASS;
    end else if (count_r[req_r.class_index] < CntW'(QueueDepth)) begin
      enq_st = ST_ENQUEUED;
    end else begin
      enq_st = ST_FULL;
    end
  end

  assign mctl.we    = (state_r == S_ENQ) && (enq_st == ST_ENQUEUED);
  assign mctl.waddr = {req_r.class_index,
                       PtrW'(head_r[req_r.class_index] + count_r[req_r.class_index][PtrW-1:0])};
  assign mctl.raddr = {cur, head_r[cur]};

  drr_desc_mem u_mem (
    .clk   (clk),
    .ctl   (mctl),
    .wdata ({req_r.packet_length, req_r.packet_tag}),
    .rdata (rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = in_data.opcode ? S_READ : S_ENQ;
      S_ENQ:   state_nxt = S_DONE;
      S_READ:  state_nxt = (acount_r == '0) ? S_DONE : S_WAIT;
      S_WAIT:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = fits ? S_DONE : S_READ;
      S_DONE:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '1;
      ahead_r     <= '0;
      acount_r    <= '0;
      backlog_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NumClasses; i++) begin
        quantum_r[i] <= QuantumReset;
        head_r[i]    <= '0;
        count_r[i]   <= '0;
        deficit_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index < CfgIdxW'(NumClasses)) quantum_r[cfg_index[ClsW-1:0]] <= cfg_data;
        else if (cfg_index == CfgMaskIdx) mask_r <= cfg_data[NumClasses-1:0];
      end
      if (state_r == S_IDLE && in_valid) req_r <= in_data;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_ENQ: begin
          out_r <= '{status: enq_st, served_class: '0, served_length: '0,
                     served_tag: '0, total_backlog: backlog_r + BacklogW'(mctl.we)};
          if (enq_st == ST_ENQUEUED) begin
            count_r[req_r.class_index] <= count_r[req_r.class_index] + 1'b1;
            if (count_r[req_r.class_index] == '0) begin
              // join the active ring at its tail, seeded with the quantum (1 if the quantum is zero)
              order_r[ClsW'(ahead_r + acount_r[ClsW-1:0])] <= req_r.class_index;
              acount_r <= acount_r + 1'b1;
              deficit_r[req_r.class_index] <= qeff;
            end
          end
          if (mctl.we) backlog_r <= backlog_r + 1'b1;
          out_valid_r <= 1'b1;
        end
        S_READ: if (acount_r == '0) begin
          out_r <= '{status: ST_EMPTY, served_class: '0, served_length: '0,
                     served_tag: '0, total_backlog: backlog_r};
          out_valid_r <= 1'b1;
        end
        S_CHECK: begin
          deficit_r[cur] <= dsum;
          if (fits) begin
            out_r.status        <= ST_DEQUEUED;
            out_r.served_class  <= cur;
            out_r.served_length <= plen;
            out_r.served_tag    <= rdata[TagW-1:0];
            out_r.total_backlog <= backlog_r - 1'b1;
            backlog_r <= backlog_r - 1'b1;
            head_r[cur]  <= head_r[cur] + 1'b1;
            count_r[cur] <= count_r[cur] - 1'b1;
            if (count_r[cur] == CntW'(1)) begin
              ahead_r  <= ahead_r + 1'b1;
              acount_r <= acount_r - 1'b1;
            end
            out_valid_r <= 1'b1;
          end else begin
            // rotate: move the head class to the ring tail
            ahead_r <= ahead_r + 1'b1;
            order_r[ClsW'(ahead_r + acount_r[ClsW-1:0])] <= cur;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> state_r == S_DONE) else $error("result outside done");
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acount_r <= (ClsW+1)'(NumClasses)) else $error("active ring overflow");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accept while busy");
`endif
endmodule

[rtl/drr_desc_mem.sv]
// Descriptor store: length and tag of every queued packet, one write and one read port.
// Depends on drr_pkg.
module drr_desc_mem
  import drr_pkg::*;
(
  input  logic                       clk,
  input  mem_ctl_t                   ctl,
  input  logic [LenW+TagW-1:0]       wdata,
  output logic [LenW+TagW-1:0]       rdata
);
  logic [LenW+TagW-1:0] mem [NumClasses*QueueDepth];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    rdata <= mem[ctl.raddr];
  end
endmodule
